// File: sv/pcwsd_pkg.sv
// package: types, constants and state codes for the per-core work-stealing deques
package pcwsd_pkg;

  localparam int CORES       = 8;
  localparam int SLOT_BITS   = 4;
  localparam int HANDLE_BITS = 32;
  localparam int CORE_BITS   = $clog2(CORES);
  localparam int CNT_BITS    = SLOT_BITS + 1;
  localparam int SLOTS       = 1 << SLOT_BITS;
  localparam int ADDR_BITS   = CORE_BITS + SLOT_BITS;

  typedef enum logic [2:0] {
    ST_PUSHED = 3'd0,
    ST_FULL   = 3'd1,
    ST_POPPED = 3'd2,
    ST_STOLEN = 3'd3,
    ST_NONE   = 3'd4
  } status_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  core;
    logic [31:0] handle_in;
    logic [2:0]  start_offset;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] handle_out;
    logic [2:0]  source_core;
  } out_item_t;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'd0,
    FSM_READ = 2'd1,
    FSM_OUT  = 2'd2
  } fsm_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch the accepted beat, decide and update the counters
    logic commit;   // apply the slot memory write of a push decision
    logic load_out; // register the result
  } cmd_t;

endpackage

// File: sv/pcwsd_ctrl.sv
// controller: sequences accept, decide/read, and result handoff
module pcwsd_ctrl
  import pcwsd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  fsm_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= FSM_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state_r)
      FSM_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = FSM_READ;
        end
      end
      FSM_READ: begin
        cmd.commit   = 1'b1;
        cmd.load_out = 1'b1;
        state_nxt    = FSM_OUT;
      end
      FSM_OUT: begin
        out_valid = 1'b1;
        // next beat may enter as this result leaves
        in_ready  = out_ready;
        if (out_ready) begin
          if (in_valid) begin
            cmd.capture = 1'b1;
            state_nxt   = FSM_READ;
          end else begin
            state_nxt = FSM_IDLE;
          end
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

endmodule

// File: sv/pcwsd_dp.sv
// datapath: head/tail counters, rotating victim select, slot memory, result register
module pcwsd_dp
  import pcwsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      cmd,
  input  in_item_t  in_item,
  output out_item_t out_item
);

  logic [CNT_BITS-1:0]    head_r [CORES];
  logic [CNT_BITS-1:0]    tail_r [CORES];
  logic [HANDLE_BITS-1:0] mem [CORES*SLOTS];
  logic [HANDLE_BITS-1:0] rdata_r;

  logic [CORES-1:0]     nonempty;
  logic [CORES-1:0]     notfull;
  logic                 own;
  logic [CORE_BITS-1:0] req_c;
  logic [CORE_BITS-1:0] off_c;
  logic [CORE_BITS-1:0] victim;
  logic                 found;
  status_t              dec_st;
  logic [CORE_BITS-1:0] dec_core;
  logic [ADDR_BITS-1:0] dec_addr;
  logic [HANDLE_BITS-1:0] wdata;

  status_t                st_r;
  logic [CORE_BITS-1:0]   src_r;
  logic [ADDR_BITS-1:0]   addr_r;
  logic [HANDLE_BITS-1:0] wdata_r;

  assign req_c = in_item.core[CORE_BITS-1:0];
  assign own   = ({29'd0, in_item.core} < 32'(CORES));
  assign off_c = CORE_BITS'(32'(in_item.start_offset) % CORES);
  assign wdata = HANDLE_BITS'(in_item.handle_in);

  always_comb begin
    for (int c = 0; c < CORES; c++) begin
      nonempty[c] = (head_r[c] != tail_r[c]);
      notfull[c]  = ((head_r[c] - tail_r[c]) < CNT_BITS'(SLOTS));
    end
  end

  // rotating priority pick: first nonempty non-requester from offset
  always_comb begin
    logic [CORE_BITS-1:0] j;
    victim = '0;
    found  = 1'b0;
    for (int i = CORES - 1; i >= 0; i--) begin
      j = CORE_BITS'((32'(off_c) + i) % CORES);
      if (nonempty[j] && !(own && j == req_c)) begin
        victim = j;
        found  = 1'b1;
      end
    end
  end

  always_comb begin
    dec_core = '0;
    dec_addr = '0;
    if (!in_item.kind) begin
      dec_st   = (own && notfull[req_c]) ? ST_PUSHED : ST_FULL;
      dec_addr = {req_c, head_r[req_c][SLOT_BITS-1:0]};
    end else if (own && nonempty[req_c]) begin
      dec_st   = ST_POPPED;
      dec_core = req_c;
      dec_addr = {req_c, SLOT_BITS'(head_r[req_c] - 1'b1)};
    end else if (found) begin
      dec_st   = ST_STOLEN;
      dec_core = victim;
      dec_addr = {victim, tail_r[victim][SLOT_BITS-1:0]};
    end else begin
      dec_st = ST_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      st_r    <= dec_st;
      src_r   <= dec_core;
      addr_r  <= dec_addr;
      wdata_r <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) rdata_r <= mem[dec_addr];
    if (cmd.commit && st_r == ST_PUSHED) mem[addr_r] <= wdata_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CORES; c++) begin
        head_r[c] <= '0;
        tail_r[c] <= '0;
      end
    end else if (cmd.capture) begin
      unique case (dec_st)
        ST_PUSHED: head_r[req_c] <= head_r[req_c] + 1'b1;
        ST_POPPED: head_r[req_c] <= head_r[req_c] - 1'b1;
        ST_STOLEN: tail_r[victim] <= tail_r[victim] + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_item.status      <= st_r;
      out_item.source_core <= 3'(src_r);
      out_item.handle_out  <= (st_r == ST_POPPED || st_r == ST_STOLEN)
                              ? 32'(rdata_r) : 32'd0;
    end
  end

endmodule

// File: sv/per_core_work_stealing_deques.sv
// top level: per-core work-stealing deque scheduler
//  channel | dir | handshake             | payload
//  in_     | in  | in_valid / in_ready   | in_data   (in_item_t)
//  out_    | out | out_valid / out_ready | out_data  (out_item_t)
// an item is decided and its slot memory read at accept, then registered as the result.
// a new beat is accepted in the cycle its predecessor's result is taken, and none is
// accepted while an item is still being decided, so the block holds one item at a time.
// rst_n synchronously clears all counters; slot memory is not cleared.
// a stalled out_ready holds the result and blocks new beats.
module per_core_work_stealing_deques
  import pcwsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  cmd_t cmd;

  pcwsd_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .cmd
  );

  pcwsd_dp u_dp (
    .clk, .rst_n, .cmd, .in_item(in_data), .out_item(out_data)
  );

  a_cap_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |-> in_valid && in_ready)
    else $error("capture without accepted beat");

  a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> ##1 out_valid)
    else $error("result not presented two cycles after accept");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_NONE || out_data.status == ST_PUSHED
                  || out_data.status == ST_FULL) |-> out_data.handle_out == 32'd0)
    else $error("handle given without supply");

endmodule
